>>> hw/rtl/irld_pkg.sv
package irld_pkg;

  // Header layout
  localparam logic [7:0] RUN_LEN_BIAS = 8'd3;
  localparam logic [6:0] GROUP_MASK   = 7'h7f;

  // Varint group geometry
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned GROUP_W   = 7;
  localparam int unsigned SHIFT_W   = 7;

  // Token kinds, carried on tuser
  localparam logic TOKEN_LITERAL = 1'b0;
  localparam logic TOKEN_RUN     = 1'b1;

  // Parser phases
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LITERAL = 4'b0010,
    PH_DELTA   = 4'b0100,
    PH_BASE    = 4'b1000
  } phase_t;

  // One decoded token
  typedef struct packed {
    logic              kind;
    logic [VAL_W-1:0]  value;
    logic [7:0]        delta;
    logic [7:0]        count;
    logic              last;
  } token_t;

endpackage

>>> hw/rtl/irld_in_stage.sv
module irld_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       step_en,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       load;

  // Accept a new beat when empty or when the held byte moves on this cycle
  assign in_tready = !valid_r || step_en;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (step_en) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

>>> hw/rtl/irld_parse.sv
module irld_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            signed_values,
  input  logic            step_en,
  input  logic [7:0]      byte_data,
  output logic            emit,
  output irld_pkg::token_t token
);
  import irld_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         lit_left_r, lit_left_nxt;
  logic [7:0]         rep_len_r, rep_len_nxt;
  logic [7:0]         delta_r, delta_nxt;
  logic [VAL_W-1:0]   accum_r, accum_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;

  logic [VAL_W-1:0]   group_sh;
  logic [VAL_W-1:0]   acc_grow;
  logic [SHIFT_W-1:0] shift_grow;
  logic [VAL_W-1:0]   raw_val;
  logic [VAL_W-1:0]   dec_val;
  logic               vdone;

  // Varint group insertion; groups at bit 64 and above are dropped
  assign group_sh   = {{(VAL_W-GROUP_W){1'b0}}, byte_data[6:0] & GROUP_MASK}
                      << shift_r[5:0];
  assign acc_grow   = shift_r[6] ? accum_r : (accum_r | group_sh);
  assign shift_grow = shift_r[6] ? shift_r : shift_r + SHIFT_W'(GROUP_W);
  assign vdone      = !byte_data[7];

  // Zigzag undo
  assign raw_val = acc_grow;
  assign dec_val = signed_values ? ((raw_val >> 1) ^ {VAL_W{raw_val[0]}}) : raw_val;

  always_comb begin
    phase_nxt    = phase_r;
    lit_left_nxt = lit_left_r;
    rep_len_nxt  = rep_len_r;
    delta_nxt    = delta_r;
    accum_nxt    = accum_r;
    shift_nxt    = shift_r;
    emit         = 1'b0;
    token.kind   = TOKEN_LITERAL;
    token.value  = dec_val;
    token.delta  = 8'd0;
    token.count  = 8'd1;
    token.last   = 1'b0;
    unique case (phase_r)
      PH_HEADER: begin
        if (byte_data[7]) begin
          lit_left_nxt = 8'(~byte_data + 8'd1);
          phase_nxt    = PH_LITERAL;
        end else begin
          rep_len_nxt = byte_data + RUN_LEN_BIAS;
          phase_nxt   = PH_DELTA;
        end
        accum_nxt = '0;
        shift_nxt = '0;
      end
      PH_DELTA: begin
        delta_nxt = byte_data;
        phase_nxt = PH_BASE;
      end
      PH_LITERAL: begin
        accum_nxt = acc_grow;
        shift_nxt = shift_grow;
        if (vdone) begin
          emit         = 1'b1;
          accum_nxt    = '0;
          shift_nxt    = '0;
          lit_left_nxt = lit_left_r - 8'd1;
          token.last   = (lit_left_r == 8'd1);
          if (lit_left_r == 8'd1) begin
            phase_nxt = PH_HEADER;
          end
        end
      end
      PH_BASE: begin
        accum_nxt = acc_grow;
        shift_nxt = shift_grow;
        if (vdone) begin
          emit        = 1'b1;
          accum_nxt   = '0;
          shift_nxt   = '0;
          token.kind  = TOKEN_RUN;
          token.delta = delta_r;
          token.count = rep_len_r;
          token.last  = 1'b1;
          phase_nxt   = PH_HEADER;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  // Parser state advances only on a consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      lit_left_r <= '0;
      rep_len_r  <= '0;
      delta_r    <= '0;
      accum_r    <= '0;
      shift_r    <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      lit_left_r <= lit_left_nxt;
      rep_len_r  <= rep_len_nxt;
      delta_r    <= delta_nxt;
      accum_r    <= accum_nxt;
      shift_r    <= shift_nxt;
    end
  end

endmodule

>>> hw/rtl/irld_out_stage.sv
module irld_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  irld_pkg::token_t token,
  output logic             room,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [79:0]      out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);
  import irld_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  token_t tok_r;

  // Slot is free when empty or when the held beat leaves this cycle
  assign room = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r <= token;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {tok_r.count, tok_r.delta, tok_r.value};
  assign out_tuser  = tok_r.kind;
  assign out_tlast  = tok_r.last;

endmodule

>>> hw/rtl/integer_run_length_decoder.sv
// Run-length decoder for a byte stream of literal blocks and repeat blocks.
// One encoded byte is taken per cycle while the result side does not stall,
// whatever mix of headers, delta bytes and varint bytes arrives. A byte is
// held in the input register until it is consumed, is parsed by the
// header/varint logic, and its token (if any) is then held in the result
// register until taken. The input side keeps flowing while a result waits,
// until that result is still untaken when the next token is due. Literal
// tokens carry run_count 1 and run_delta 0; block_end (tlast) marks the last
// token of a header block. signed_values (cfg_wdata) selects zigzag decoding
// and is sampled when each token is formed.
module integer_run_length_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // signed_values
  // encoded byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] in_byte
  // decoded tokens
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,     // [63:0] out_value, [71:64] run_delta,
                                     // [79:72] run_count
  output logic        out_tuser,     // token_kind
  output logic        out_tlast      // block_end
);
  import irld_pkg::*;

  logic       signed_r;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       room;
  logic       step_en;
  logic       emit;
  token_t     token;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_r <= 1'b0;
    end else if (cfg_we) begin
      signed_r <= cfg_wdata;
    end
  end

  // A held byte is consumed unless its token finds the result slot stalled
  assign step_en = byte_valid && (room || !emit);

  irld_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .step_en    (step_en),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  irld_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .signed_values (signed_r),
    .step_en       (step_en),
    .byte_data     (byte_data),
    .emit          (emit),
    .token         (token)
  );

  irld_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en && emit),
    .token      (token),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Run tokens always close their block
  a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == TOKEN_RUN) |-> out_tlast)
    else $error("run token without block_end");

  // Literal tokens describe exactly one value with no step
  a_lit_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == TOKEN_LITERAL) |->
      (out_tdata[79:72] == 8'd1) && (out_tdata[71:64] == 8'd0))
    else $error("literal token with bad count or delta");

  // Run lengths stay within the header range
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == TOKEN_RUN) |->
      (out_tdata[79:72] >= 8'd3) && (out_tdata[79:72] <= 8'd130))
    else $error("run count outside header range");

  // A token is never formed while the result slot is occupied and stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(step_en && emit))
    else $error("token overwrites a stalled result");

endmodule

>>> tb/integer_run_length_decoder_tb.sv
`timescale 1ns / 1ps

module integer_run_length_decoder_tb;
  import irld_pkg::*;

  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRINT_CAP     = 40;

  // Tracks the parser state and keeps the tokens still due from the block
  class token_scoreboard;
    phase_t      phase;
    logic [7:0]  lits_left;
    logic [7:0]  run_len;
    logic [7:0]  run_step;
    logic [63:0] accum;
    logic [6:0]  shift;
    bit          zigzag;
    token_t      due_q[$];
    int          errors;

    function new();
      phase     = PH_HEADER;
      lits_left = '0;
      run_len   = '0;
      run_step  = '0;
      accum     = '0;
      shift     = '0;
      zigzag    = 1'b0;
      errors    = 0;
    endfunction

    function void set_signed(bit s);
      zigzag = s;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Add one base-128 group; groups past bit 63 are dropped
    function bit add_group(logic [7:0] b);
      if (shift < 7'd64) begin
        accum = accum | ({57'b0, b[6:0] & GROUP_MASK} << shift);
        shift = shift + 7'd7;
      end
      return !b[7];
    endfunction

    function logic [63:0] close_varint();
      logic [63:0] v;
      v     = accum;
      accum = '0;
      shift = '0;
      if (zigzag) v = (v >> 1) ^ {64{v[0]}};
      return v;
    endfunction

    // One accepted input beat: advance the parser, queue a token if one completes
    function void note_byte(logic [7:0] b);
      token_t t;
      case (phase)
        PH_HEADER: begin
          if (b[7]) begin
            lits_left = 8'd0 - b;
            phase     = PH_LITERAL;
          end else begin
            run_len = b + RUN_LEN_BIAS;
            phase   = PH_DELTA;
          end
          accum = '0;
          shift = '0;
        end
        PH_DELTA: begin
          run_step = b;
          phase    = PH_BASE;
        end
        PH_LITERAL: begin
          if (add_group(b)) begin
            t.kind    = TOKEN_LITERAL;
            t.value   = close_varint();
            t.delta   = 8'd0;
            t.count   = 8'd1;
            lits_left = lits_left - 8'd1;
            t.last    = (lits_left == 8'd0);
            if (t.last) phase = PH_HEADER;
            due_q.push_back(t);
          end
        end
        PH_BASE: begin
          if (add_group(b)) begin
            t.kind  = TOKEN_RUN;
            t.value = close_varint();
            t.delta = run_step;
            t.count = run_len;
            t.last  = 1'b1;
            phase   = PH_HEADER;
            due_q.push_back(t);
          end
        end
        default: phase = PH_HEADER;
      endcase
    endfunction

    // Printing is capped so a broken block cannot flood the log
    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (errors < PRINT_CAP)
        $display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_token(token_t got);
      token_t want;
      if (due_q.size() == 0) begin
        report_mismatch("unexpected token value", got.value, '0);
      end else begin
        want = due_q.pop_front();
        if (got.kind !== want.kind)   report_mismatch("token_kind", got.kind, want.kind);
        if (got.value !== want.value) report_mismatch("out_value", got.value, want.value);
        if (got.delta !== want.delta) report_mismatch("run_delta", got.delta, want.delta);
        if (got.count !== want.count) report_mismatch("run_count", got.count, want.count);
        if (got.last !== want.last)   report_mismatch("block_end", got.last, want.last);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;   // [63:0] out_value, [71:64] run_delta, [79:72] run_count
  logic        out_tuser;   // token_kind
  logic        out_tlast;   // block_end

  token_scoreboard sb = new();
  token_t          seen_tok;

  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int          bytes_sent = 0;
  int          hold_left = 0;
  bit          press_now = 1'b0;
  bit          stall_done = 1'b0;

  integer_run_length_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Token sink: random backpressure plus one long hold-off when asked
  always @(negedge clk) begin
    if (press_now && !stall_done) begin
      hold_left  = HOLD_CYCLES;
      stall_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Sample result beats
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_tok.kind  = out_tuser;
      seen_tok.value = out_tdata[63:0];
      seen_tok.delta = out_tdata[71:64];
      seen_tok.count = out_tdata[79:72];
      seen_tok.last  = out_tlast;
      sb.check_token(seen_tok);
    end
  end

  // Entered and left at a falling edge
  task send_byte(logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  function int varint_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    else return $urandom_range(11, 12);   // runs past bit 63
  endfunction

  task send_varint(int nbytes);
    int unsigned r;
    logic [6:0]  g;
    for (int i = 0; i < nbytes; i++) begin
      r = $urandom_range(9);
      g = (r == 0) ? 7'h00 : (r == 1) ? 7'h7f : 7'($urandom_range(127));
      send_byte({i != nbytes - 1, g});
    end
  endtask

  // Mostly well-formed blocks with random content, some raw noise bytes
  task send_block();
    int unsigned r;
    int          n;
    r = $urandom_range(99);
    if (r < 3) begin
      n = $urandom_range(100, 128);
      send_byte(8'd0 - 8'(n));
      repeat (n) send_varint(1);
    end else if (r < 48) begin
      n = $urandom_range(1, 6);
      send_byte(8'd0 - 8'(n));
      repeat (n) send_varint(varint_len());
    end else if (r < 92) begin
      send_byte(8'($urandom_range(127)));
      send_byte(8'($urandom_range(255)));
      send_varint(varint_len());
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
    end
  endtask

  task run_random(int nbytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) send_block();
  endtask

  // Wait for every due token, then let trailing bytes settle
  task drain();
    int     n;
    token_t lost;
    n = 0;
    in_tvalid <= 1'b0;
    while (sb.pending() > 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (sb.pending() > 0) begin
      lost = sb.due_q.pop_front();
      sb.report_mismatch("token never seen", lost.value, '0);
    end
  endtask

  task write_signed(bit s);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_signed(s);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: unsigned extremes
    write_signed(1'b0);
    send_byte(8'hff);                 // one literal, value zero
    send_byte(8'h00);
    send_byte(8'h00);                 // shortest run, largest positive delta
    send_byte(8'h7f);
    send_byte(8'h7f);
    send_byte(8'h7f);                 // longest run, most negative delta, all-ones base
    send_byte(8'h80);
    repeat (9) send_byte(8'hff);
    send_byte(8'h01);
    drain();

    // Directed: zigzag of the all-ones pattern
    write_signed(1'b1);
    send_byte(8'hff);
    repeat (9) send_byte(8'hff);
    send_byte(8'h01);
    drain();

    // Sender idles a little, sink stalls often; leave a literal block open
    in_idle_pct  = 10;
    out_idle_pct = 51;
    run_random(230);
    send_byte(8'hfd);
    send_varint(varint_len());
    drain();

    // Zigzag switched off in the middle of that literal block
    write_signed(1'b0);
    in_idle_pct  = 51;
    out_idle_pct = 10;
    repeat (2) send_varint(varint_len());
    run_random(230);
    drain();

    // Full rate, with one long sink hold-off so the input backs up
    write_signed(1'b1);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    press_now    = 1'b1;
    run_random(240);
    drain();

    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/irld_pkg.sv
hw/rtl/irld_in_stage.sv
hw/rtl/irld_parse.sv
hw/rtl/irld_out_stage.sv
hw/rtl/integer_run_length_decoder.sv
tb/integer_run_length_decoder_tb.sv
